// ===== sv/tpds_pkg.sv =====
`timescale 1ns / 1ps

package tpds_pkg;

    localparam int STORE_DEPTH = 8;
    localparam int SLOT_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    localparam logic [2:0]  STYLUS_TOOL       = 3'd2;
    localparam logic [15:0] DECAY_POS_RESET   = 16'd42598;
    localparam logic [15:0] DECAY_PRESS_RESET = 16'd58982;
    localparam logic [2:0]  HISTORY_RESET     = 3'd6;
    localparam logic [16:0] WEIGHT_ONE        = 17'h10000;

    // Configuration register indexes
    localparam logic [1:0] REG_POS_DECAY   = 2'd0;
    localparam logic [1:0] REG_PRESS_DECAY = 2'd1;
    localparam logic [1:0] REG_HISTORY     = 2'd2;
    localparam logic [1:0] REG_BYPASS      = 2'd3;

    // Accumulator widths: value * weight summed over the window
    localparam int ACC16_W = 16 + 17 + SLOT_W + 1;
    localparam int ACC32_W = 32 + 17 + SLOT_W + 1;
    localparam int WSUM_W  = 17 + SLOT_W + 1;

    // Divider control: which quotient is being worked on
    typedef enum logic [2:0] {
        DIV_X,
        DIV_Y,
        DIV_P,
        DIV_S,
        DIV_T
    } div_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     store;      // write the accepted word and clear sums
        logic     accum;      // add the entry at the walk index
        logic     div_load;   // load divider with selected operands
        logic     div_step;   // one restoring step
        logic     div_save;   // latch quotient into result register
        div_sel_t sel;
    } tpds_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic             stylus;    // current walk entry is a stylus point
        logic [CNT_W-1:0] fill;      // window length after the write
    } tpds_stat_t;

endpackage

// ===== sv/tpds_ctrl.sv =====
`timescale 1ns / 1ps

module tpds_ctrl
    import tpds_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  logic             stylus_bypass,
    input  tpds_stat_t       stat,
    output tpds_cmd_t        cmd,
    output logic [SLOT_W-1:0] walk_k
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [5:0]        step_reg, step_next;
    div_sel_t          sel_reg, sel_next;
    logic              out_valid_reg, out_valid_next;
    logic              last_div;

    localparam logic [5:0] STEPS16 = 6'd16;
    localparam logic [5:0] STEPS32 = 6'd32;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign walk_k    = k_reg[SLOT_W-1:0];
    assign last_div  = (sel_reg == DIV_T);

    // Sequence the walk, the five divisions and the output handoff
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        step_next      = step_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.sel        = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.store  = 1'b1;
                    k_next     = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.accum = 1'b1;
                k_next    = k_reg + 1'b1;
                if ((k_next == stat.fill) || (stylus_bypass && stat.stylus))
                begin
                    sel_next   = DIV_X;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = (sel_reg == DIV_T) ? STEPS32 : STEPS16;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg != '0)
                begin
                    cmd.div_step = 1'b1;
                    step_next    = step_reg - 1'b1;
                end
                else
                begin
                    cmd.div_save = 1'b1;
                    if (last_div)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = ST_OUT;
                    end
                    else
                    begin
                        sel_next   = div_sel_t'(sel_reg + 1'b1);
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            step_reg      <= '0;
            sel_reg       <= DIV_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            step_reg      <= step_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/tpds_dp.sv =====
`timescale 1ns / 1ps

module tpds_dp
    import tpds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tpds_cmd_t         cmd,
    input  logic [SLOT_W-1:0] walk_k,
    output tpds_stat_t        stat,
    input  logic [15:0]       pos_decay,
    input  logic [15:0]       pressure_decay,
    input  logic [2:0]        history_len,
    input  logic [15:0]       x_pos,
    input  logic [15:0]       y_pos,
    input  logic [15:0]       pressure_in,
    input  logic [15:0]       contact_size,
    input  logic [2:0]        tool_type,
    input  logic [31:0]       timestamp,
    output logic [15:0]       x_out,
    output logic [15:0]       y_out,
    output logic [15:0]       pressure_out,
    output logic [15:0]       size_out,
    output logic [2:0]        tool_out,
    output logic [31:0]       time_out
);

    logic [31:0] pos_mem   [STORE_DEPTH];
    logic [31:0] ps_mem    [STORE_DEPTH];
    logic [31:0] time_mem  [STORE_DEPTH];
    logic [2:0]  tool_mem  [STORE_DEPTH];

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [SLOT_W-1:0] cur_reg;

    logic [16:0]       wp_reg, wq_reg;
    logic [ACC16_W-1:0] sx_reg, sy_reg, sp_reg, ss_reg;
    logic [ACC32_W-1:0] st_reg;
    logic [WSUM_W-1:0]  sw_reg, sq_reg;
    logic [2:0]         tool_reg;

    logic [ACC32_W-1:0] rem_reg, num_sel, rem_try;
    logic [ACC32_W-1:0] den_reg;
    logic [ACC32_W-1:0] den_sel;
    logic [31:0]        quo_reg;
    logic [5:0]         sh_sel;
    logic [15:0]        xq_reg, yq_reg, pq_reg, sq_q_reg;
    logic [31:0]        tq_reg;

    logic [SLOT_W-1:0] rd_idx;
    logic [CNT_W-1:0]  back_k;
    logic [31:0]       rd_pos_reg, rd_ps_reg, rd_time_reg;
    logic [2:0]        rd_tool_reg;
    logic [32:0]       wp_mul, wq_mul;
    logic [32:0]       x_mul, y_mul, p_mul, s_mul;
    logic [48:0]       t_mul;
    logic [CNT_W-1:0]  limit, fill_inc;

    // Window length after this write
    always_comb
    begin
        limit    = CNT_W'(history_len) + 1'b1;
        if (limit > CNT_W'(STORE_DEPTH))
        begin
            limit = CNT_W'(STORE_DEPTH);
        end
        fill_inc = fill_reg + 1'b1;
        fill_next = (fill_inc > limit) ? limit : fill_inc;
        slot_next = (slot_reg == SLOT_W'(STORE_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
    end

    // Prefetch index: the entry after the one being added, newest slot minus k+1
    always_comb
    begin
        back_k = CNT_W'(walk_k) + 1'b1;
        if (CNT_W'(cur_reg) >= back_k)
        begin
            rd_idx = SLOT_W'(CNT_W'(cur_reg) - back_k);
        end
        else
        begin
            rd_idx = SLOT_W'(STORE_DEPTH + int'(cur_reg) - int'(back_k));
        end
        wp_mul  = wp_reg * pos_decay;
        wq_mul  = wq_reg * pressure_decay;
        x_mul   = rd_pos_reg[15:0] * wp_reg;
        y_mul   = rd_pos_reg[31:16] * wp_reg;
        p_mul   = rd_ps_reg[15:0] * wq_reg;
        s_mul   = rd_ps_reg[31:16] * wq_reg;
        t_mul   = rd_time_reg * wp_reg;
    end

    assign stat.stylus = (rd_tool_reg == STYLUS_TOOL);
    assign stat.fill   = fill_reg;

    // Store the new point
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            pos_mem[slot_reg]  <= {y_pos, x_pos};
            ps_mem[slot_reg]   <= {contact_size, pressure_in};
            time_mem[slot_reg] <= timestamp;
            tool_mem[slot_reg] <= tool_type;
        end
    end

    // Read port: take the newest word straight from the input, then fetch ahead
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            rd_pos_reg  <= {y_pos, x_pos};
            rd_ps_reg   <= {contact_size, pressure_in};
            rd_time_reg <= timestamp;
            rd_tool_reg <= tool_type;
        end
        else if (cmd.accum)
        begin
            rd_pos_reg  <= pos_mem[rd_idx];
            rd_ps_reg   <= ps_mem[rd_idx];
            rd_time_reg <= time_mem[rd_idx];
            rd_tool_reg <= tool_mem[rd_idx];
        end
    end

    // Ring pointer and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            fill_reg <= '0;
        end
        else if (cmd.store)
        begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
        end
    end

    // Accumulate weighted sums over the walk
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            cur_reg  <= slot_reg;
            tool_reg <= tool_type;
            wp_reg   <= WEIGHT_ONE;
            wq_reg   <= WEIGHT_ONE;
            sx_reg   <= '0;
            sy_reg   <= '0;
            sp_reg   <= '0;
            ss_reg   <= '0;
            st_reg   <= '0;
            sw_reg   <= '0;
            sq_reg   <= '0;
        end
        else if (cmd.accum)
        begin
            sx_reg <= sx_reg + ACC16_W'(x_mul);
            sy_reg <= sy_reg + ACC16_W'(y_mul);
            sp_reg <= sp_reg + ACC16_W'(p_mul);
            ss_reg <= ss_reg + ACC16_W'(s_mul);
            st_reg <= st_reg + ACC32_W'(t_mul);
            sw_reg <= sw_reg + WSUM_W'(wp_reg);
            sq_reg <= sq_reg + WSUM_W'(wq_reg);
            wp_reg <= wp_mul[32:16];
            wq_reg <= wq_mul[32:16];
        end
    end

    // Select divider operands; quotients fit 16 or 32 bits
    always_comb
    begin
        case (cmd.sel)
            DIV_X:
            begin
                num_sel = ACC32_W'(sx_reg);
                den_sel = ACC32_W'(sw_reg);
                sh_sel  = 6'd16;
            end
            DIV_Y:
            begin
                num_sel = ACC32_W'(sy_reg);
                den_sel = ACC32_W'(sw_reg);
                sh_sel  = 6'd16;
            end
            DIV_P:
            begin
                num_sel = ACC32_W'(sp_reg);
                den_sel = ACC32_W'(sq_reg);
                sh_sel  = 6'd16;
            end
            DIV_S:
            begin
                num_sel = ACC32_W'(ss_reg);
                den_sel = ACC32_W'(sq_reg);
                sh_sel  = 6'd16;
            end
            DIV_T:
            begin
                num_sel = st_reg;
                den_sel = ACC32_W'(sw_reg);
                sh_sel  = 6'd32;
            end
            default:
            begin
                num_sel = '0;
                den_sel = '1;
                sh_sel  = 6'd16;
            end
        endcase
        rem_try = rem_reg - den_reg;
    end

    // Restoring division, one quotient bit per step, from the top down
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg <= num_sel;
            den_reg <= den_sel << (sh_sel - 6'd1);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= den_reg)
            begin
                rem_reg <= rem_try;
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
            den_reg <= den_reg >> 1;
        end
    end

    // Latch each quotient
    always_ff @(posedge clk)
    begin
        if (cmd.div_save)
        begin
            case (cmd.sel)
                DIV_X:   xq_reg   <= quo_reg[15:0];
                DIV_Y:   yq_reg   <= quo_reg[15:0];
                DIV_P:   pq_reg   <= quo_reg[15:0];
                DIV_S:   sq_q_reg <= quo_reg[15:0];
                DIV_T:   tq_reg   <= quo_reg;
                default: tq_reg   <= quo_reg;
            endcase
        end
    end

    assign x_out        = xq_reg;
    assign y_out        = yq_reg;
    assign pressure_out = pq_reg;
    assign size_out     = sq_q_reg;
    assign tool_out     = tool_reg;
    assign time_out     = tq_reg;

endmodule

// ===== sv/touch_point_decay_smoother.sv =====
`timescale 1ns / 1ps
// Flow: after a word is taken, the walk adds 1 to 8 window entries, one each cycle,
// then the shared serial divider works out four 16-bit quotients and one 32-bit
// quotient in turn before the result is shown on out_valid.
// One word is worked on at a time; in_stall holds off the next word until the
// result has been taken.
// Reset: asynchronous active low; window empties, configuration registers take defaults.
module touch_point_decay_smoother
    import tpds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] x_pos,
    input  logic [15:0] y_pos,
    input  logic [15:0] pressure_in,
    input  logic [15:0] contact_size,
    input  logic [2:0]  tool_type,
    input  logic [31:0] timestamp,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] x_out,
    output logic [15:0] y_out,
    output logic [15:0] pressure_out,
    output logic [15:0] size_out,
    output logic [2:0]  tool_out,
    output logic [31:0] time_out
);

    logic [15:0] pos_decay_reg, press_decay_reg;
    logic [2:0]  history_reg;
    logic        bypass_reg;

    tpds_cmd_t         cmd;
    tpds_stat_t        stat;
    logic [SLOT_W-1:0] walk_k;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_decay_reg   <= DECAY_POS_RESET;
            press_decay_reg <= DECAY_PRESS_RESET;
            history_reg     <= HISTORY_RESET;
            bypass_reg      <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POS_DECAY:   pos_decay_reg   <= cfg_data;
                REG_PRESS_DECAY: press_decay_reg <= cfg_data;
                REG_HISTORY:     history_reg     <= cfg_data[2:0];
                REG_BYPASS:      bypass_reg      <= cfg_data[0];
                default:         bypass_reg      <= bypass_reg;
            endcase
        end
    end

    tpds_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .stylus_bypass (bypass_reg),
        .stat          (stat),
        .cmd           (cmd),
        .walk_k        (walk_k)
    );

    tpds_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .walk_k         (walk_k),
        .stat           (stat),
        .pos_decay      (pos_decay_reg),
        .pressure_decay (press_decay_reg),
        .history_len    (history_reg),
        .x_pos          (x_pos),
        .y_pos          (y_pos),
        .pressure_in    (pressure_in),
        .contact_size   (contact_size),
        .tool_type      (tool_type),
        .timestamp      (timestamp),
        .x_out          (x_out),
        .y_out          (y_out),
        .pressure_out   (pressure_out),
        .size_out       (size_out),
        .tool_out       (tool_out),
        .time_out       (time_out)
    );

`ifndef NO_ASSERTIONS
    // No new word while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("input taken while result pending");
    // Window never exceeds the store
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.fill <= CNT_W'(STORE_DEPTH))
        else $error("fill count overflow");
    // Accepting a word starts the walk on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (cmd.accum && walk_k == '0))
        else $error("walk did not start");
`endif

endmodule
